### src/mtf_pkg.sv
// ----------------------------------------------------------------------------
// Move-to-front list package
// Operation and status codes, and the control group that is sent to every cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ACCESS = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  // One request's effect on the row of cells, decided at the top level.
  typedef struct packed {
    logic append;  // write the value into the cell at the tail
    logic remove;  // cells at or after the match take their right neighbor
    logic access;  // cells up to the match take their left neighbor
  } ctl_t;

endpackage

### src/mtf_req_if.sv
// ----------------------------------------------------------------------------
// Move-to-front list request channel
// Valid/ready channel that carries one list operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtf_req_if;
  import mtf_pkg::*;

  logic                       valid;
  logic                       ready;
  op_t                        op;
  logic signed [VALUE_W-1:0]  value;
  logic        [INDEX_W-1:0]  index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);

endinterface

### src/mtf_rsp_if.sv
// ----------------------------------------------------------------------------
// Move-to-front list response channel
// Valid/ready channel that carries the result of one list operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtf_rsp_if;
  import mtf_pkg::*;

  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic        [INDEX_W-1:0]  position;
  logic signed [VALUE_W-1:0]  read_value;
  logic        [COUNT_W-1:0]  count;

  modport source (output valid, output status, output position, output read_value,
                  output count, input ready);
  modport sink   (input valid, input status, input position, input read_value,
                  input count, output ready);

endinterface

### src/mtf_cell.sv
// ----------------------------------------------------------------------------
// Move-to-front list cell
// Holds one slot, compares it with the request value and shifts with its
// neighbors on remove and access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 5
) (
  input  logic                  clk,
  input  mtf_pkg::ctl_t         ctl,
  input  logic [CW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  found_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match_first,
  output logic                  found_out
);
  import mtf_pkg::*;

  localparam logic [CW-1:0] MY_POS   = CW'(IDX);
  localparam logic [CW:0]   NEXT_POS = (CW + 1)'(IDX + 1);

  logic live;
  logic match;

  assign live        = MY_POS < count;
  assign match       = live && (data == value);
  assign match_first = match && !found_in;
  assign found_out   = found_in || match;

  // A cell at or past the match on remove pulls from the right while its
  // neighbor is still inside the list; on access every cell up to the match
  // pulls from the left, and the head cell's left input is the value itself.
  always_ff @(posedge clk) begin
    if (ctl.append && (count == MY_POS)) begin
      data <= value;
    end else if (ctl.remove && found_out && (NEXT_POS < {1'b0, count})) begin
      data <= right_data;
    end else if (ctl.access && !found_in) begin
      data <= left_data;
    end
  end

endmodule

### src/move_to_front_list_top.sv
// ----------------------------------------------------------------------------
// Move-to-front list top level
// The response is registered; while it waits unread, no request is taken.
// Throughput: one request per cycle; the row of cells compares and shifts in
// the same cycle, and a waiting response is held in the output register.
// Reset: the entry count and the response valid clear; slots are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module move_to_front_list_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mtf_req_if.sink   req,
  mtf_rsp_if.source rsp
);
  import mtf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         out_valid;
  status_t                      rsp_status;
  logic [INDEX_W-1:0]           rsp_position;
  logic signed [VALUE_W-1:0]    rsp_read_value;
  logic [COUNT_W-1:0]           rsp_count;

  logic                         fire;
  logic                         full;
  logic                         found_all;
  logic signed [DATA_WIDTH-1:0] vdata;
  logic [DEPTH:0]               found;
  logic [DEPTH-1:0]             match_first;
  logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
  ctl_t                         ctl;
  status_t                      status_next;
  logic [INDEX_W-1:0]           position_next;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic [INDEX_W-1:0]           hit_pos;
  logic                         idx_ok;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  assign vdata     = DATA_WIDTH'(req.value);
  assign full      = count == CW'(DEPTH);
  assign found[0]  = 1'b0;
  assign found_all = found[DEPTH];

  assign ctl.append = fire && (req.op == OP_APPEND) && !full;
  assign ctl.remove = fire && (req.op == OP_REMOVE) && found_all;
  assign ctl.access = fire && (req.op == OP_ACCESS) && found_all;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (g == 0) begin : g_head
      assign left_data = vdata;
    end else begin : g_mid
      assign left_data = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[g];
    end else begin : g_body
      assign right_data = cell_data[g+1];
    end

    mtf_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .value       (vdata),
      .left_data   (left_data),
      .right_data  (right_data),
      .found_in    (found[g]),
      .data        (cell_data[g]),
      .match_first (match_first[g]),
      .found_out   (found[g+1])
    );
  end

  // Only one cell can flag the first match, so its position is an OR.
  always_comb begin
    hit_pos = '0;
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_first[i]) begin
        hit_pos = hit_pos | INDEX_W'(i);
      end
      if (32'(req.index) == i) begin
        rd_data = cell_data[i];
      end
    end
  end

  assign idx_ok = (32'(req.index) < 32'(count)) && (32'(req.index) < DEPTH);

  always_comb begin
    status_next   = ST_OK;
    position_next = '0;
    count_next    = count;
    case (req.op)
      OP_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found_all) begin
          position_next = hit_pos;
          count_next    = count - 1'b1;
        end else begin
          status_next = ST_NO_MATCH;
        end
      end
      OP_ACCESS: begin
        if (found_all) begin
          position_next = hit_pos;
        end else begin
          status_next = ST_NO_MATCH;
        end
      end
      OP_READ: begin
        position_next = req.index;
        if (!idx_ok) begin
          status_next = ST_PAST_END;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else if (fire) begin
      out_valid <= 1'b1;
      count     <= count_next;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status     <= status_next;
      rsp_position   <= position_next;
      rsp_count      <= COUNT_W'(count_next);
      rsp_read_value <= ((req.op == OP_READ) && idx_ok) ? VALUE_W'(rd_data) : '0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = rsp_status;
  assign rsp.position   = rsp_position;
  assign rsp.read_value = rsp_read_value;
  assign rsp.count      = rsp_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds the list depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_first))
    else $error("more than one cell claims the first match");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    fire && (req.op == OP_APPEND) && full |=> count == $past(count))
    else $error("append to a full list changed the entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    fire && (req.op == OP_REMOVE) && found_all |=> count == $past(count) - 1'b1)
    else $error("remove of a match did not drop the entry count by one");
`endif

endmodule
